### design/bwlru_pkg.sv
package bwlru_pkg;

    localparam int SLOT_W   = 6;
    localparam int TIME_W   = 32;
    localparam int BYTES_W  = 32;
    localparam int TOTAL_W  = 40;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_W   = 16;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_USED_W  = SLOT_W + BYTES_W + TOTAL_W;
    localparam int OUT_TDATA_W = 80;

    // Upper bound on eviction results produced by one pass.
    localparam int MAX_RESULTS = 64;
    localparam int VIC_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0]     MAX_BYTES_RST = 32'd419430400;
    localparam logic [FRAC_W-1:0] CLEANUP_RST = 16'd13107;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEANUP   = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_EVICT  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LR_SUB,
        ST_LR_ADD,
        ST_EV_INIT,
        ST_SCAN,
        ST_PICK,
        ST_CHECK,
        ST_EMIT
    } t_state;

endpackage

### design/byte_weighted_lru_evictor_core.sv
// A load word goes through the subtract, add and emit states before its result is registered, a
// remove through subtract and emit, and an unused command (or an out-of-range slot) through emit
// only; the next word is accepted after that. An eviction pass scans the whole slot memory, one
// entry per cycle, for each victim, and each victim then goes through the pick and check states.
// A result waits while the previous one is still held. Reset is synchronous, active low; a
// clearing pass then marks every slot invalid before any word is accepted.
module byte_weighted_lru_evictor_core #(
    parameter int ENTRIES   = 64,
    parameter int SIZE_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata, from bit 0 up: slot, access_time, entry_bytes, zero fill.
    input  logic [bwlru_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: command.
    input  logic [bwlru_pkg::CMD_W-1:0]          i_s_axis_tuser,
    // Result stream.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata, from bit 0 up: result_slot, result_bytes, total_after, zero fill.
    output logic [bwlru_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // tuser: evicted.
    output logic                                 o_m_axis_tuser,
    output logic                                 o_m_axis_tlast,
    // Configuration writes.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bwlru_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bwlru_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SLOT_W  = bwlru_pkg::SLOT_W;
    localparam int TIME_W  = bwlru_pkg::TIME_W;
    localparam int BYTES_W = bwlru_pkg::BYTES_W;
    localparam int TOTAL_W = bwlru_pkg::TOTAL_W;
    localparam int FRAC_W  = bwlru_pkg::FRAC_W;
    localparam int VIC_W   = bwlru_pkg::VIC_W;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int DATA_W  = TIME_W + SIZE_BITS;
    localparam int SUM_W   = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;
    localparam int PROD_W  = 32 + FRAC_W;
    localparam logic [63:0] SIZE_MAX = (64'd1 << SIZE_BITS) - 64'd1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    function automatic logic [TOTAL_W-1:0] f_sat_sub(input logic [TOTAL_W-1:0] a,
                                                      input logic [SIZE_BITS-1:0] b);
        logic [SUM_W-1:0] wa;
        logic [SUM_W-1:0] wb;
        wa = SUM_W'(a);
        wb = SUM_W'(b);
        f_sat_sub = (wb >= wa) ? '0 : TOTAL_W'(wa - wb);
    endfunction

    function automatic logic [TOTAL_W-1:0] f_sat_add(input logic [TOTAL_W-1:0] a,
                                                      input logic [SIZE_BITS-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        f_sat_add = (s > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(s);
    endfunction

    // Slot memories: valid marks (cleared after reset) and {time, size}.
    logic              mem_valid [ENTRIES];
    logic [DATA_W-1:0] mem_data  [ENTRIES];
    logic              r_vrd;
    logic [DATA_W-1:0] r_drd;

    bwlru_pkg::t_state r_state;
    bwlru_pkg::t_state n_state;

    logic [31:0]          r_max_bytes;
    logic [FRAC_W-1:0]    r_cleanup;
    logic [IDX_W-1:0]     r_clr_addr;
    logic [TOTAL_W-1:0]   r_total;
    logic [TOTAL_W-1:0]   n_total;
    logic                 r_out_valid;

    bwlru_pkg::t_cmd      r_cmd;
    logic [IDX_W-1:0]     r_slot_idx;
    logic [TIME_W-1:0]    r_in_time;
    logic [BYTES_W-1:0]   r_in_bytes;
    logic [31:0]          r_freed;
    logic                 r_below;
    logic [TOTAL_W-1:0]   r_target;

    logic [CNT_W-1:0]     r_cnt;
    logic                 r_pend;
    logic [IDX_W-1:0]     r_pidx;
    logic                 r_found;
    logic [1:0]           r_nval;
    logic [IDX_W-1:0]     r_best;
    logic [TIME_W-1:0]    r_best_time;
    logic [SIZE_BITS-1:0] r_best_size;
    logic [VIC_W-1:0]     r_nvic;

    logic [SLOT_W-1:0]    r_res_slot;
    logic [BYTES_W-1:0]   r_res_bytes;
    logic                 r_res_ev;
    logic                 r_res_last;

    logic [SLOT_W-1:0]    r_o_slot;
    logic [BYTES_W-1:0]   r_o_bytes;
    logic [TOTAL_W-1:0]   r_o_total;
    logic                 r_o_ev;
    logic                 r_o_last;

    // Input word fields.
    bwlru_pkg::t_cmd      in_cmd;
    logic [SLOT_W-1:0]    in_slot;
    logic [TIME_W-1:0]    in_time;
    logic [BYTES_W-1:0]   in_bytes;
    logic                 in_range;
    logic [IDX_W-1:0]     in_idx;
    logic                 accept;
    logic                 out_free;

    logic                 scan_more;
    logic [IDX_W-1:0]     scan_idx;
    logic [IDX_W-1:0]     rd_addr;
    logic                 v_we;
    logic [IDX_W-1:0]     v_waddr;
    logic                 v_wdata;
    logic                 d_we;
    logic [SIZE_BITS-1:0] rd_size;
    logic [TIME_W-1:0]    rd_time;
    logic [SIZE_BITS-1:0] sat_bytes;
    logic [PROD_W-1:0]    freed_prod;

    assign in_cmd   = bwlru_pkg::t_cmd'(i_s_axis_tuser);
    assign in_slot  = i_s_axis_tdata[SLOT_W-1:0];
    assign in_time  = i_s_axis_tdata[SLOT_W +: TIME_W];
    assign in_bytes = i_s_axis_tdata[SLOT_W + TIME_W +: BYTES_W];
    assign in_range = 32'(in_slot) < 32'(ENTRIES);
    assign in_idx   = in_range ? IDX_W'(in_slot) : '0;

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    assign scan_more = r_cnt < CNT_W'(ENTRIES);
    assign scan_idx  = scan_more ? IDX_W'(r_cnt) : '0;

    assign rd_size   = r_drd[SIZE_BITS-1:0];
    assign rd_time   = r_drd[DATA_W-1:SIZE_BITS];
    assign sat_bytes = (64'(r_in_bytes) > SIZE_MAX) ? SIZE_BITS'(SIZE_MAX)
                                                    : SIZE_BITS'(r_in_bytes);
    assign freed_prod = PROD_W'(r_max_bytes) * PROD_W'(r_cleanup);

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(bwlru_pkg::OUT_TDATA_W - bwlru_pkg::OUT_USED_W){1'b0}},
                              r_o_total, r_o_bytes, r_o_slot};
    assign o_m_axis_tuser  = r_o_ev;
    assign o_m_axis_tlast  = r_o_last;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bwlru_pkg::ST_CLEAR: begin
                if (r_clr_addr == IDX_W'(ENTRIES - 1)) begin
                    n_state = bwlru_pkg::ST_IDLE;
                end
            end
            bwlru_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        bwlru_pkg::CMD_LOAD, bwlru_pkg::CMD_REMOVE: begin
                            n_state = in_range ? bwlru_pkg::ST_LR_SUB : bwlru_pkg::ST_EMIT;
                        end
                        bwlru_pkg::CMD_EVICT: n_state = bwlru_pkg::ST_EV_INIT;
                        bwlru_pkg::CMD_NOP:   n_state = bwlru_pkg::ST_EMIT;
                    endcase
                end
            end
            bwlru_pkg::ST_LR_SUB: begin
                n_state = (r_cmd == bwlru_pkg::CMD_LOAD) ? bwlru_pkg::ST_LR_ADD
                                                         : bwlru_pkg::ST_EMIT;
            end
            bwlru_pkg::ST_LR_ADD:  n_state = bwlru_pkg::ST_EMIT;
            bwlru_pkg::ST_EV_INIT: n_state = bwlru_pkg::ST_SCAN;
            bwlru_pkg::ST_SCAN: begin
                if (!scan_more && !r_pend) begin
                    n_state = bwlru_pkg::ST_PICK;
                end
            end
            bwlru_pkg::ST_PICK: begin
                n_state = r_found ? bwlru_pkg::ST_CHECK : bwlru_pkg::ST_EMIT;
            end
            bwlru_pkg::ST_CHECK: n_state = bwlru_pkg::ST_EMIT;
            bwlru_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = r_res_last ? bwlru_pkg::ST_IDLE : bwlru_pkg::ST_SCAN;
                end
            end
        endcase
    end

    // Handshake, memory controls and the next running total.
    always_comb begin
        o_s_axis_tready = 1'b0;
        rd_addr = scan_idx;
        v_we    = 1'b0;
        v_waddr = r_slot_idx;
        v_wdata = 1'b0;
        d_we    = 1'b0;
        n_total = r_total;
        unique case (r_state)
            bwlru_pkg::ST_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = r_clr_addr;
            end
            bwlru_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                rd_addr = in_idx;
            end
            bwlru_pkg::ST_LR_SUB: begin
                v_we = (r_cmd == bwlru_pkg::CMD_REMOVE);
                if (r_vrd) begin
                    n_total = f_sat_sub(r_total, rd_size);
                end
            end
            bwlru_pkg::ST_LR_ADD: begin
                v_we    = 1'b1;
                v_wdata = 1'b1;
                d_we    = 1'b1;
                n_total = f_sat_add(r_total, sat_bytes);
            end
            bwlru_pkg::ST_PICK: begin
                if (r_found) begin
                    v_we    = 1'b1;
                    v_waddr = r_best;
                    n_total = f_sat_sub(r_total, r_best_size);
                end
            end
            bwlru_pkg::ST_EV_INIT, bwlru_pkg::ST_SCAN,
            bwlru_pkg::ST_CHECK, bwlru_pkg::ST_EMIT: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            mem_valid[v_waddr] <= v_wdata;
        end
        r_vrd <= mem_valid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            mem_data[r_slot_idx] <= {r_in_time, sat_bytes};
        end
        r_drd <= mem_data[rd_addr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bwlru_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_max_bytes <= bwlru_pkg::MAX_BYTES_RST;
            r_cleanup   <= bwlru_pkg::CLEANUP_RST;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (r_state == bwlru_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == bwlru_pkg::ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && i_cfg_index == bwlru_pkg::CFG_MAX_BYTES) begin
                r_max_bytes <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == bwlru_pkg::CFG_CLEANUP) begin
                r_cleanup <= i_cfg_data[FRAC_W-1:0];
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bwlru_pkg::ST_IDLE: begin
                if (accept) begin
                    r_cmd       <= in_cmd;
                    r_slot_idx  <= in_idx;
                    r_in_time   <= in_time;
                    r_in_bytes  <= in_bytes;
                    r_freed     <= freed_prod[PROD_W-1:FRAC_W];
                    r_res_slot  <= in_slot;
                    r_res_bytes <= '0;
                    r_res_ev    <= 1'b0;
                    r_res_last  <= 1'b1;
                end
            end
            bwlru_pkg::ST_LR_SUB: begin
                r_res_bytes <= r_vrd ? BYTES_W'(rd_size) : '0;
            end
            bwlru_pkg::ST_LR_ADD: begin
                r_res_bytes <= BYTES_W'(sat_bytes);
            end
            bwlru_pkg::ST_EV_INIT: begin
                // A free share above the total means the pass runs until empty.
                r_below  <= TOTAL_W'(r_freed) > r_total;
                r_target <= r_total - TOTAL_W'(r_freed);
                r_cnt    <= '0;
                r_pend   <= 1'b0;
                r_found  <= 1'b0;
                r_nval   <= '0;
                r_nvic   <= '0;
            end
            bwlru_pkg::ST_SCAN: begin
                r_pend <= scan_more;
                r_pidx <= scan_idx;
                if (scan_more) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (r_pend && r_vrd) begin
                    if (r_nval != 2'd2) begin
                        r_nval <= r_nval + 1'b1;
                    end
                    // Strict compare keeps the lowest index among equal times.
                    if (!r_found || rd_time < r_best_time) begin
                        r_found     <= 1'b1;
                        r_best      <= r_pidx;
                        r_best_time <= rd_time;
                        r_best_size <= rd_size;
                    end
                end
            end
            bwlru_pkg::ST_PICK: begin
                r_res_slot  <= r_found ? SLOT_W'(r_best) : '0;
                r_res_bytes <= r_found ? BYTES_W'(r_best_size) : '0;
                r_res_ev    <= r_found;
                r_res_last  <= !r_found;
                if (r_found) begin
                    r_nvic <= r_nvic + 1'b1;
                end
            end
            bwlru_pkg::ST_CHECK: begin
                // Fewer than two valid slots seen means the victim was the last one.
                r_res_last <= (r_nvic == VIC_W'(bwlru_pkg::MAX_RESULTS))
                           || (r_nval != 2'd2)
                           || (!r_below && r_total <= r_target);
            end
            bwlru_pkg::ST_EMIT: begin
                if (out_free) begin
                    r_o_slot  <= r_res_slot;
                    r_o_bytes <= r_res_bytes;
                    r_o_total <= r_total;
                    r_o_ev    <= r_res_ev;
                    r_o_last  <= r_res_last;
                    if (!r_res_last) begin
                        r_cnt   <= '0;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_nval  <= '0;
                    end
                end
            end
            bwlru_pkg::ST_CLEAR: begin
            end
        endcase
    end

    a_empty_pick_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bwlru_pkg::ST_PICK && !r_found) |-> (r_nvic == '0))
        else $error("empty scan after an eviction in the same pass");

    a_evict_lowers_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bwlru_pkg::ST_PICK && r_found) |=> (r_total <= $past(r_total)))
        else $error("eviction raised the byte total");

    a_pass_limit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bwlru_pkg::ST_CHECK && r_nvic == VIC_W'(bwlru_pkg::MAX_RESULTS))
        |=> r_res_last)
        else $error("pass limit reached without final word");

endmodule

### test/tb_byte_weighted_lru_evictor_core.sv
module tb_byte_weighted_lru_evictor_core;

    localparam int TBL_ENTRIES   = 64;
    // One full scan of the slot table plus some slack for the block to settle.
    localparam int SETTLE_CYCLES = TBL_ENTRIES + 16;
    localparam logic [bwlru_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [bwlru_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [bwlru_pkg::SLOT_W-1:0]  slot;
        logic [bwlru_pkg::BYTES_W-1:0] bytes;
        logic [bwlru_pkg::TOTAL_W-1:0] total;
        logic                          evicted;
        logic                          last;
    } t_evict_result;

    logic                                  i_clk;
    logic                                  i_rst_n         = 1'b0;
    logic                                  i_s_axis_tvalid = 1'b0;
    logic                                  o_s_axis_tready;
    logic [bwlru_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata  = '0;
    logic [bwlru_pkg::CMD_W-1:0]           i_s_axis_tuser  = '0;
    logic                                  o_m_axis_tvalid;
    logic                                  i_m_axis_tready = 1'b0;
    logic [bwlru_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata;
    logic                                  o_m_axis_tuser;
    logic                                  o_m_axis_tlast;
    logic                                  i_cfg_valid     = 1'b0;
    logic                                  o_cfg_ready;
    logic [bwlru_pkg::CFG_IDX_W-1:0]       i_cfg_index     = '0;
    logic [bwlru_pkg::CFG_DATA_W-1:0]      i_cfg_data      = '0;

    // Mirror of the slot table and of the configuration.
    logic                                  tbl_valid [TBL_ENTRIES];
    logic [bwlru_pkg::TIME_W-1:0]          tbl_time  [TBL_ENTRIES];
    logic [bwlru_pkg::BYTES_W-1:0]         tbl_size  [TBL_ENTRIES];
    logic [bwlru_pkg::TOTAL_W-1:0]         tbl_total;
    logic [31:0]                           cap_bytes;
    logic [bwlru_pkg::FRAC_W-1:0]          free_frac;

    t_evict_result                         awaited_results [$];
    int                                    mismatch_count  = 0;
    int                                    send_idle_pct   = 0;
    int                                    recv_stall_pct  = 0;
    logic [bwlru_pkg::TIME_W-1:0]          stamp_base      = 32'd1000;

    byte_weighted_lru_evictor_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        for (int i = 0; i < TBL_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_time[i]  = '0;
            tbl_size[i]  = '0;
        end
        tbl_total = '0;
        cap_bytes = bwlru_pkg::MAX_BYTES_RST;
        free_frac = bwlru_pkg::CLEANUP_RST;
    end

    function automatic logic [bwlru_pkg::TOTAL_W-1:0] total_plus(
            input logic [bwlru_pkg::TOTAL_W-1:0] a,
            input logic [bwlru_pkg::BYTES_W-1:0] b);
        logic [bwlru_pkg::TOTAL_W:0] sum;
        sum = {1'b0, a} + {9'd0, b};
        return sum[bwlru_pkg::TOTAL_W] ? {bwlru_pkg::TOTAL_W{1'b1}}
                                       : sum[bwlru_pkg::TOTAL_W-1:0];
    endfunction

    function automatic logic [bwlru_pkg::TOTAL_W-1:0] total_minus(
            input logic [bwlru_pkg::TOTAL_W-1:0] a,
            input logic [bwlru_pkg::BYTES_W-1:0] b);
        logic [bwlru_pkg::TOTAL_W-1:0] wide_b;
        wide_b = {8'd0, b};
        return (wide_b >= a) ? '0 : a - wide_b;
    endfunction

    // Updates the table mirror for one command and queues the result words it causes.
    function automatic void apply_cache_command(input bwlru_pkg::t_cmd cmd,
                                                input logic [bwlru_pkg::SLOT_W-1:0] slot,
                                                input logic [bwlru_pkg::TIME_W-1:0] stamp,
                                                input logic [bwlru_pkg::BYTES_W-1:0] size);
        t_evict_result                 r;
        t_evict_result                 pass_q [$];
        logic [47:0]                   product;
        logic [bwlru_pkg::TOTAL_W-1:0] freed;
        logic [bwlru_pkg::TOTAL_W-1:0] target;
        logic [bwlru_pkg::BYTES_W-1:0] bytes;
        logic                          below_zero;
        logic                          found;
        int                            best;
        case (cmd)
            bwlru_pkg::CMD_LOAD, bwlru_pkg::CMD_REMOVE: begin
                bytes = '0;
                if (tbl_valid[slot]) begin
                    tbl_total = total_minus(tbl_total, tbl_size[slot]);
                    bytes = tbl_size[slot];
                end
                if (cmd == bwlru_pkg::CMD_LOAD) begin
                    bytes = size;
                    tbl_valid[slot] = 1'b1;
                    tbl_time[slot]  = stamp;
                    tbl_size[slot]  = size;
                    tbl_total = total_plus(tbl_total, size);
                end else begin
                    tbl_valid[slot] = 1'b0;
                end
                r = '{slot: slot, bytes: bytes, total: tbl_total, evicted: 1'b0, last: 1'b1};
                awaited_results = {awaited_results, r};
            end
            bwlru_pkg::CMD_EVICT: begin
                product = {16'd0, cap_bytes} * {32'd0, free_frac};
                freed = 40'(product >> 16);
                below_zero = freed > tbl_total;
                target = below_zero ? '0 : tbl_total - freed;
                for (int n = 0; n < bwlru_pkg::MAX_RESULTS; n++) begin
                    found = 1'b0;
                    best = 0;
                    for (int i = 0; i < TBL_ENTRIES; i++) begin
                        if (tbl_valid[i] && (!found || tbl_time[i] < tbl_time[best])) begin
                            best = i;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        break;
                    tbl_valid[best] = 1'b0;
                    tbl_total = total_minus(tbl_total, tbl_size[best]);
                    r = '{slot: 6'(best), bytes: tbl_size[best], total: tbl_total,
                          evicted: 1'b1, last: 1'b0};
                    pass_q = {pass_q, r};
                    if (!below_zero && tbl_total <= target)
                        break;
                end
                if (pass_q.size() == 0) begin
                    r = '{slot: '0, bytes: '0, total: tbl_total, evicted: 1'b0, last: 1'b1};
                    pass_q = {pass_q, r};
                end else begin
                    pass_q[pass_q.size() - 1].last = 1'b1;
                end
                awaited_results = {awaited_results, pass_q};
            end
            default: begin
                r = '{slot: slot, bytes: '0, total: tbl_total, evicted: 1'b0, last: 1'b1};
                awaited_results = {awaited_results, r};
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_evict_result seen;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result word with nothing awaited",
                                64'(o_m_axis_tdata[bwlru_pkg::SLOT_W-1:0]), 64'd0);
            end else begin
                seen = awaited_results.pop_front();
                if (o_m_axis_tdata[bwlru_pkg::SLOT_W-1:0] !== seen.slot)
                    report_mismatch("result_slot",
                                    64'(o_m_axis_tdata[bwlru_pkg::SLOT_W-1:0]),
                                    64'(seen.slot));
                if (o_m_axis_tdata[bwlru_pkg::SLOT_W +: bwlru_pkg::BYTES_W] !== seen.bytes)
                    report_mismatch("result_bytes",
                        64'(o_m_axis_tdata[bwlru_pkg::SLOT_W +: bwlru_pkg::BYTES_W]),
                        64'(seen.bytes));
                if (o_m_axis_tdata[bwlru_pkg::SLOT_W + bwlru_pkg::BYTES_W +: bwlru_pkg::TOTAL_W]
                        !== seen.total)
                    report_mismatch("total_after",
                        64'(o_m_axis_tdata[bwlru_pkg::SLOT_W + bwlru_pkg::BYTES_W
                                           +: bwlru_pkg::TOTAL_W]),
                        64'(seen.total));
                if (o_m_axis_tuser !== seen.evicted)
                    report_mismatch("evicted", 64'(o_m_axis_tuser), 64'(seen.evicted));
                if (o_m_axis_tlast !== seen.last)
                    report_mismatch("last", 64'(o_m_axis_tlast), 64'(seen.last));
            end
        end
    end

    // Mostly increasing stamps, with repeats for ties and the odd arbitrary value.
    function automatic logic [bwlru_pkg::TIME_W-1:0] next_stamp();
        case ($urandom_range(3))
            0: return $urandom;
            1: return stamp_base;
            default: begin
                stamp_base = stamp_base + 32'($urandom_range(1, 1000));
                return stamp_base;
            end
        endcase
    endfunction

    function automatic logic [bwlru_pkg::BYTES_W-1:0] pick_size();
        case ($urandom_range(3))
            0: return 32'($urandom_range(0, 255));
            1: return 32'($urandom_range(0, 32'h0100_0000));
            2: return 32'($urandom_range(32'h0400_0000, 32'h1000_0000));
            default: return $urandom;
        endcase
    endfunction

    // Called at a clock edge; valid is left high after the handshake so that the next
    // word can follow back to back.
    task automatic send_command(input bwlru_pkg::t_cmd cmd,
                                input logic [bwlru_pkg::SLOT_W-1:0] slot,
                                input logic [bwlru_pkg::TIME_W-1:0] stamp,
                                input logic [bwlru_pkg::BYTES_W-1:0] size);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {2'b00, size, stamp, slot};
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_cache_command(cmd, slot, stamp, size);
    endtask

    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write_word(input logic [bwlru_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [bwlru_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes both registers; the two unused indexes get random data and must change nothing.
    task automatic write_config(input logic [31:0] cap,
                                input logic [bwlru_pkg::FRAC_W-1:0] frac);
        cfg_write_word(CFG_SPARE_A, $urandom);
        cfg_write_word(bwlru_pkg::CFG_MAX_BYTES, cap);
        cap_bytes = cap;
        cfg_write_word(CFG_SPARE_B, $urandom);
        cfg_write_word(bwlru_pkg::CFG_CLEANUP, {16'($urandom_range(0, 65535)), frac});
        free_frac = frac;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_commands();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_command(bwlru_pkg::CMD_EVICT, 6'd0, '0, '0);
        send_command(bwlru_pkg::CMD_NOP, 6'd63, '1, '1);
        send_command(bwlru_pkg::CMD_REMOVE, 6'd5, '0, '0);
        send_command(bwlru_pkg::CMD_LOAD, 6'd0, 32'd0, 32'd0);
        send_command(bwlru_pkg::CMD_LOAD, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(bwlru_pkg::CMD_LOAD, 6'd1, 32'd100, 32'd1000);
        // Replacement of a valid slot, then a second slot with the same stamp.
        send_command(bwlru_pkg::CMD_LOAD, 6'd1, 32'd50, 32'd2000);
        send_command(bwlru_pkg::CMD_LOAD, 6'd2, 32'd50, 32'd3000);
        send_command(bwlru_pkg::CMD_REMOVE, 6'd63, '1, '1);
        send_command(bwlru_pkg::CMD_LOAD, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(bwlru_pkg::CMD_LOAD, 6'd42, 32'h8000_0000, 32'h0500_0000);
        send_command(bwlru_pkg::CMD_EVICT, 6'd21, 32'h5555_5555, 32'hAAAA_AAAA);
        send_command(bwlru_pkg::CMD_EVICT, 6'd42, '0, '0);
        send_command(bwlru_pkg::CMD_EVICT, 6'd0, '0, '0);
    endtask

    task automatic test_config_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_results_drained();
        // Largest free share against a full table of small entries: one pass empties it.
        write_config(32'hFFFF_FFFF, 16'hFFFF);
        for (int s = 0; s < TBL_ENTRIES; s++)
            send_command(bwlru_pkg::CMD_LOAD, 6'(s), next_stamp(),
                         32'($urandom_range(0, 32'h00FF_FFFF)));
        send_command(bwlru_pkg::CMD_EVICT, 6'($urandom_range(63)), $urandom, $urandom);
        send_command(bwlru_pkg::CMD_EVICT, 6'($urandom_range(63)), $urandom, $urandom);
        wait_results_drained();
        // Nothing to free: exactly one victim, even when it holds no bytes.
        write_config(32'd0, 16'hFFFF);
        send_command(bwlru_pkg::CMD_LOAD, 6'd7, 32'd10, 32'd0);
        send_command(bwlru_pkg::CMD_LOAD, 6'd8, 32'd20, 32'd500);
        send_command(bwlru_pkg::CMD_EVICT, 6'd0, '0, '0);
        wait_results_drained();
        write_config(32'hFFFF_FFFF, 16'd0);
        send_command(bwlru_pkg::CMD_EVICT, 6'd0, '0, '0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int item_count, input logic [31:0] cap,
                                       input logic [bwlru_pkg::FRAC_W-1:0] frac);
        int sent;
        int burst;
        wait_results_drained();
        write_config(cap, frac);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < item_count) begin
            if ($urandom_range(9) == 0) begin
                send_command(bwlru_pkg::t_cmd'(2'($urandom_range(3))),
                             6'($urandom_range(63)), next_stamp(), pick_size());
                sent++;
            end else begin
                // A few table updates followed by an eviction pass.
                burst = $urandom_range(1, 6);
                repeat (burst) begin
                    if ($urandom_range(5) == 0)
                        send_command(bwlru_pkg::CMD_REMOVE, 6'($urandom_range(63)),
                                     $urandom, $urandom);
                    else
                        send_command(bwlru_pkg::CMD_LOAD, 6'($urandom_range(63)),
                                     next_stamp(), pick_size());
                    sent++;
                end
                send_command(bwlru_pkg::CMD_EVICT, 6'($urandom_range(63)),
                             $urandom, $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_commands();
        test_config_extremes();
        test_random_traffic(0, 0, 35, bwlru_pkg::MAX_BYTES_RST, bwlru_pkg::CLEANUP_RST);
        test_random_traffic(67, 0, 35, $urandom, 16'($urandom_range(0, 65535)));
        test_random_traffic(0, 67, 35, 32'($urandom_range(0, 32'h4000_0000)), 16'h8000);
        test_random_traffic(25, 25, 35, 32'h0800_0000, 16'hFFFF);
        wait_results_drained();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
